### design/kfb_pkg.sv
package kfb_pkg;

    localparam int MAX_KNOTS   = 16;
    localparam int KIDX_W      = 4;
    localparam int CNT_W       = 5;
    localparam int T_FRAC_BITS = 16;
    localparam int KEY_W       = 16;
    localparam int LVL_W       = 24;
    localparam int VAL_W       = 24;
    localparam int SLP_W       = 28;
    localparam int ACC_W       = 64;

    localparam logic [1:0] ADDR_ACTIVE_KNOTS = 2'd0;

    localparam logic [1:0] ST_EVAL  = 2'd0;
    localparam logic [1:0] ST_WRITE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic signed [LVL_W-1:0] level;
        logic signed [LVL_W-1:0] hleft;
        logic signed [LVL_W-1:0] hright;
    } knot_t;

    typedef struct packed {
        logic                    start;
        logic [T_FRAC_BITS:0]    u;
        logic signed [LVL_W:0]   p0;
        logic signed [LVL_W:0]   p1;
        logic signed [LVL_W:0]   p2;
        logic signed [LVL_W:0]   p3;
    } bez_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [VAL_W-1:0] value;
        logic signed [SLP_W-1:0] slope;
    } bez_rsp_t;

endpackage

### design/kfb_divider.sv
module kfb_divider
    import kfb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [KEY_W-1:0]       num,
    input  logic [KEY_W-1:0]       den,
    output logic                   done,
    output logic [T_FRAC_BITS-1:0] quot
);

    localparam int STEP_W = $clog2(T_FRAC_BITS + 1);

    logic [STEP_W-1:0]      step_reg;
    logic                   busy_reg;
    logic [KEY_W:0]         rem_reg;
    logic [KEY_W-1:0]       den_reg;
    logic [T_FRAC_BITS-1:0] q_reg;
    logic [KEY_W+1:0]       trial;

    assign trial = {rem_reg, 1'b0} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(T_FRAC_BITS);
                rem_reg  <= {1'b0, num};
                den_reg  <= den;
                q_reg    <= '0;
            end
            else if (busy_reg)
            begin
                if (!trial[KEY_W+1])
                begin
                    rem_reg <= trial[KEY_W:0];
                    q_reg   <= {q_reg[T_FRAC_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[KEY_W-1:0], 1'b0};
                    q_reg   <= {q_reg[T_FRAC_BITS-2:0], 1'b0};
                end
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    assign quot = q_reg;

endmodule

### design/kfb_bezier.sv
module kfb_bezier
    import kfb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  bez_req_t req,
    output bez_rsp_t rsp
);

    localparam int UW = T_FRAC_BITS + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_WW, S_WU, S_UU, S_B0, S_B1, S_B2, S_B3,
        S_V0, S_V1, S_V2, S_V3, S_S0, S_S1, S_S2, S_DONE
    } state_t;

    state_t state_reg;
    logic [UW-1:0] u_reg, w_reg, ww_reg, wu_reg, uu_reg;
    logic [UW-1:0] b0_reg, b1_reg, b2_reg, b3_reg;
    logic signed [LVL_W:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [ACC_W-1:0] vacc_reg, sacc_reg;

    logic [UW-1:0]            ma, mb;
    logic [2*UW-1:0]          mprod;
    logic [UW-1:0]            mshift;
    logic signed [UW+1:0]     sa;
    logic signed [LVL_W+1:0]  sb;
    logic signed [UW+LVL_W+3:0] sprod;
    logic signed [ACC_W-1:0]  vround, sround;

    always_comb
    begin
        ma = u_reg;
        mb = u_reg;
        sa = '0;
        sb = '0;
        case (state_reg)
            S_WW:    begin ma = w_reg;  mb = w_reg; end
            S_WU:    begin ma = w_reg;  mb = u_reg; end
            S_UU:    begin ma = u_reg;  mb = u_reg; end
            S_B0:    begin ma = ww_reg; mb = w_reg; end
            S_B1:    begin ma = ww_reg; mb = u_reg; end
            S_B2:    begin ma = uu_reg; mb = w_reg; end
            S_B3:    begin ma = uu_reg; mb = u_reg; end
            S_V0:    begin sa = {2'b00, b0_reg}; sb = {p0_reg[LVL_W], p0_reg}; end
            S_V1:    begin sa = {2'b00, b1_reg}; sb = {p1_reg[LVL_W], p1_reg}; end
            S_V2:    begin sa = {2'b00, b2_reg}; sb = {p2_reg[LVL_W], p2_reg}; end
            S_V3:    begin sa = {2'b00, b3_reg}; sb = {p3_reg[LVL_W], p3_reg}; end
            S_S0:    begin sa = {2'b00, ww_reg}; sb = p1_reg - p0_reg; end
            S_S1:    begin sa = {2'b00, wu_reg}; sb = p2_reg - p1_reg; end
            S_S2:    begin sa = {2'b00, uu_reg}; sb = p3_reg - p2_reg; end
            default: begin ma = u_reg; mb = u_reg; end
        endcase
    end

    assign mprod  = ma * mb;
    assign mshift = mprod[T_FRAC_BITS +: UW];
    assign sprod  = sa * sb;
    assign vround = vacc_reg + (ACC_W'(1) <<< (T_FRAC_BITS - 1));
    assign sround = sacc_reg + (ACC_W'(1) <<< (T_FRAC_BITS - 1));

    function automatic logic signed [SLP_W-1:0] sat_s(input logic signed [ACC_W-1:0] x,
                                                     input int bits);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = (ACC_W'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (x > hi)
            sat_s = SLP_W'(hi);
        else if (x < lo)
            sat_s = SLP_W'(lo);
        else
            sat_s = SLP_W'(x);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rsp.done  <= 1'b0;
        end
        else
        begin
            rsp.done <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        u_reg  <= req.u;
                        w_reg  <= UW'(1 << T_FRAC_BITS) - req.u;
                        p0_reg <= req.p0;
                        p1_reg <= req.p1;
                        p2_reg <= req.p2;
                        p3_reg <= req.p3;
                        vacc_reg <= '0;
                        sacc_reg <= '0;
                        state_reg <= S_WW;
                    end
                end
                S_WW: begin ww_reg <= mshift; state_reg <= S_WU; end
                S_WU: begin wu_reg <= mshift; state_reg <= S_UU; end
                S_UU: begin uu_reg <= mshift; state_reg <= S_B0; end
                S_B0: begin b0_reg <= mshift; state_reg <= S_B1; end
                S_B1: begin b1_reg <= UW'(3 * mshift); state_reg <= S_B2; end
                S_B2: begin b2_reg <= UW'(3 * mshift); state_reg <= S_B3; end
                S_B3: begin b3_reg <= mshift; state_reg <= S_V0; end
                S_V0, S_V1, S_V2:
                begin
                    vacc_reg  <= vacc_reg + ACC_W'(sprod);
                    state_reg <= state_t'(state_reg + 1'b1);
                end
                S_V3:
                begin
                    vacc_reg  <= vacc_reg + ACC_W'(sprod);
                    state_reg <= S_S0;
                end
                S_S0:
                begin
                    sacc_reg  <= sacc_reg + 3 * ACC_W'(sprod);
                    state_reg <= S_S1;
                end
                S_S1:
                begin
                    sacc_reg  <= sacc_reg + 6 * ACC_W'(sprod);
                    state_reg <= S_S2;
                end
                S_S2:
                begin
                    sacc_reg  <= sacc_reg + 3 * ACC_W'(sprod);
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    rsp.value <= VAL_W'(sat_s(vround >>> T_FRAC_BITS, VAL_W));
                    rsp.slope <= sat_s(sround >>> T_FRAC_BITS, SLP_W);
                    rsp.done  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### design/keyframe_cubic_bezier_eval.sv
// Channel  Dir  Fields (tdata from bit 0 up)
// s_axis   in   opcode, knot_index, knot_key, knot_level, handle_left,
//               handle_right, query_t
// m_axis   out  curve_value, curve_slope, status
// apb      in   active_knots at address 0
// A write word is answered with a write status. An evaluation scans the keys
// (one entry per cycle), fetches the pair, runs the restoring divider and then the
// shared multiplier sequence. The block takes no word while one is in work or while
// its result waits on m_axis. Reset clears control state and active_knots; the knot
// table holds garbage until written.
module keyframe_cubic_bezier_eval
    import kfb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,  // opcode, knot_index, knot_key, knot_level,
                                        // handle_left, handle_right, query_t
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [55:0]  m_axis_tdata,  // curve_value, curve_slope, status
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_FETCH_L, S_FETCH_R, S_DIV, S_DIV_WAIT, S_BEZ,
        S_BEZ_WAIT, S_OUT
    } state_t;

    state_t state_reg;
    logic [CNT_W-1:0] active_reg;
    knot_t store [MAX_KNOTS];
    knot_t rd_reg, left_reg;
    logic [KIDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] n_reg, idx_reg;
    logic [KEY_W-1:0] t_reg;
    logic [T_FRAC_BITS:0] u_reg;
    logic first_reg;
    logic [VAL_W-1:0] val_reg;
    logic [SLP_W-1:0] slp_reg;
    logic [1:0] status_reg;
    logic div_start;
    logic div_done;
    logic [T_FRAC_BITS-1:0] div_q;
    logic [KEY_W:0] num_w, den_w;
    bez_req_t breq;
    bez_rsp_t brsp;

    logic opcode;
    logic [KIDX_W-1:0] kidx;
    knot_t wknot;
    logic [KEY_W-1:0] qt;

    assign opcode = s_axis_tdata[0];
    assign kidx   = s_axis_tdata[4:1];
    assign wknot  = '{key: s_axis_tdata[20:5], level: s_axis_tdata[44:21],
                      hleft: s_axis_tdata[68:45], hright: s_axis_tdata[92:69]};
    assign qt     = s_axis_tdata[108:93];

    assign pready = 1'b1;
    assign prdata = {27'd0, active_reg};
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {2'b00, status_reg, slp_reg, val_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= '0;
        else if (psel && penable && pwrite && paddr == ADDR_ACTIVE_KNOTS)
            active_reg <= pwdata[CNT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready && opcode == OP_WRITE)
            store[kidx] <= wknot;
        rd_reg <= store[rd_addr];
    end

    assign num_w = {1'b0, t_reg} - {1'b0, left_reg.key};
    assign den_w = {1'b0, rd_reg.key} - {1'b0, left_reg.key};

    always_comb
    begin
        rd_addr = idx_reg[KIDX_W-1:0];
        div_start = (state_reg == S_DIV);
        breq.start = (state_reg == S_BEZ);
        breq.u  = u_reg;
        breq.p0 = {left_reg.level[LVL_W-1], left_reg.level};
        breq.p1 = {left_reg.level[LVL_W-1], left_reg.level}
                + {left_reg.hright[LVL_W-1], left_reg.hright};
        breq.p3 = {rd_reg.level[LVL_W-1], rd_reg.level};
        breq.p2 = {rd_reg.level[LVL_W-1], rd_reg.level}
                + {rd_reg.hleft[LVL_W-1], rd_reg.hleft};
    end

    kfb_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_w[KEY_W-1:0]),
        .den   (den_w[KEY_W-1:0]),
        .done  (div_done),
        .quot  (div_q)
    );

    kfb_bezier u_bez (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (breq),
        .rsp   (brsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        val_reg <= '0;
                        slp_reg <= '0;
                        idx_reg <= '0;
                        t_reg   <= qt;
                        n_reg   <= (active_reg > CNT_W'(MAX_KNOTS)) ? CNT_W'(MAX_KNOTS)
                                                                  : active_reg;
                        first_reg <= 1'b1;
                        if (opcode == OP_WRITE)
                        begin
                            status_reg <= ST_WRITE;
                            state_reg  <= S_OUT;
                        end
                        else if (active_reg == '0)
                        begin
                            status_reg <= ST_EMPTY;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            status_reg <= ST_EVAL;
                            state_reg  <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    // rd_reg is valid for idx_reg-1 once first_reg is clear.
                    if (first_reg)
                    begin
                        first_reg <= 1'b0;
                        idx_reg   <= idx_reg + 1'b1;
                    end
                    else if (rd_reg.key >= t_reg)
                    begin
                        if (idx_reg == CNT_W'(1))
                        begin
                            if (n_reg > CNT_W'(1) && rd_reg.key == t_reg)
                            begin
                                left_reg  <= rd_reg;
                                state_reg <= S_FETCH_R;
                            end
                            else
                            begin
                                val_reg   <= rd_reg.level;
                                state_reg <= S_OUT;
                            end
                        end
                        else
                        begin
                            idx_reg   <= idx_reg - CNT_W'(2);
                            state_reg <= S_FETCH_L;
                        end
                    end
                    else if (idx_reg == n_reg)
                    begin
                        val_reg   <= rd_reg.level;
                        state_reg <= S_OUT;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_FETCH_L:
                begin
                    idx_reg   <= idx_reg + 1'b1;
                    first_reg <= 1'b1;
                    state_reg <= S_FETCH_R;
                end
                S_FETCH_R:
                begin
                    // Wait for left entry then right entry on the read port.
                    if (first_reg)
                    begin
                        first_reg <= 1'b0;
                        left_reg  <= rd_reg;
                    end
                    else
                        state_reg <= S_DIV;
                    if (idx_reg == '0)
                        idx_reg <= CNT_W'(1);
                end
                S_DIV:
                begin
                    if (den_w[KEY_W] || den_w == '0 || num_w[KEY_W] || num_w == '0)
                    begin
                        u_reg     <= '0;
                        state_reg <= S_BEZ;
                    end
                    else if (num_w >= den_w)
                    begin
                        u_reg     <= (T_FRAC_BITS+1)'(1 << T_FRAC_BITS);
                        state_reg <= S_BEZ;
                    end
                    else
                        state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        u_reg     <= {1'b0, div_q};
                        state_reg <= S_BEZ;
                    end
                end
                S_BEZ:
                    state_reg <= S_BEZ_WAIT;
                S_BEZ_WAIT:
                begin
                    if (brsp.done)
                    begin
                        val_reg   <= brsp.value;
                        slp_reg   <= brsp.slope;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (m_axis_tready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### design/kfb_checker.sv
module kfb_checker
    import kfb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);

    property p_hold;
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata);
    endproperty
    a_hold: assert property (p_hold) else $error("result changed while stalled");

    property p_excl;
        @(posedge clk) disable iff (!rst_n)
        !(m_axis_tvalid && s_axis_tready);
    endproperty
    a_excl: assert property (p_excl) else $error("input ready while result pending");

    property p_status;
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[53:52] != 2'd3;
    endproperty
    a_status: assert property (p_status) else $error("bad status");

    property p_write_zero;
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[53:52] != ST_EVAL |-> m_axis_tdata[51:0] == '0;
    endproperty
    a_write_zero: assert property (p_write_zero) else $error("nonzero data");

endmodule

bind keyframe_cubic_bezier_eval kfb_checker u_kfb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
